[design/utf8v_pkg.sv]
// Package for the UTF-8 stream validator: decoder state type and constants.
// No dependencies; imported by utf8v_step and utf8_stream_validator_top.
`default_nettype none

package utf8v_pkg;

  localparam int unsigned AccumW = 21;

  localparam logic [AccumW-1:0] MinClass1  = 21'h000080;
  localparam logic [AccumW-1:0] MinClass2  = 21'h000800;
  localparam logic [AccumW-1:0] MinClass3  = 21'h010000;
  localparam logic [AccumW-1:0] MaxCodePt  = 21'h10FFFF;
  localparam logic [AccumW-1:0] SurrLow    = 21'h00D800;
  localparam logic [AccumW-1:0] SurrHigh   = 21'h00DFFF;

  localparam logic [1:0] ClassTwoByte   = 2'd1;
  localparam logic [1:0] ClassThreeByte = 2'd2;
  localparam logic [1:0] ClassFourByte  = 2'd3;

  typedef struct packed {
    logic [1:0]        pending;
    logic [AccumW-1:0] accum;
    logic [1:0]        seq_class;
    logic              err;
  } state_t;

  localparam state_t StateClear = '0;

endpackage

`default_nettype wire

[design/utf8v_step.sv]
// Combinational per-byte UTF-8 decode step: next decoder state and verdict.
// Depends on utf8v_pkg.
`default_nettype none

module utf8v_step
  import utf8v_pkg::*;
(
  input  state_t     cur_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output state_t     nxt_o,
  output logic       verdict_o
);

  state_t            upd;
  logic [AccumW-1:0] cp;
  logic [AccumW-1:0] min_cp;
  logic [1:0]        pend_dec;

  always_comb begin
    upd      = cur_i;
    cp       = {cur_i.accum[AccumW-7:0], byte_i[5:0]};
    pend_dec = cur_i.pending - 2'd1;
    unique case (cur_i.seq_class)
      ClassTwoByte:   min_cp = MinClass1;
      ClassThreeByte: min_cp = MinClass2;
      default:        min_cp = MinClass3;
    endcase

    if (!cur_i.err) begin
      if (cur_i.pending != 2'd0) begin
        if (byte_i[7:6] != 2'b10) begin
          upd.err = 1'b1;
        end else begin
          upd.accum   = cp;
          upd.pending = pend_dec;
          if (pend_dec == 2'd0) begin
            if (cp < min_cp || cp > MaxCodePt || (cp >= SurrLow && cp <= SurrHigh)) begin
              upd.err = 1'b1;
            end
          end
        end
      end else if (byte_i == 8'h00) begin
        upd.err = 1'b1;
      end else if (byte_i[7] == 1'b0) begin
        upd = cur_i;
      end else if (byte_i[7:5] == 3'b110) begin
        upd.pending   = 2'd1;
        upd.seq_class = ClassTwoByte;
        upd.accum     = {{(AccumW-5){1'b0}}, byte_i[4:0]};
      end else if (byte_i[7:4] == 4'b1110) begin
        upd.pending   = 2'd2;
        upd.seq_class = ClassThreeByte;
        upd.accum     = {{(AccumW-4){1'b0}}, byte_i[3:0]};
      end else if (byte_i[7:3] == 5'b11110) begin
        upd.pending   = 2'd3;
        upd.seq_class = ClassFourByte;
        upd.accum     = {{(AccumW-3){1'b0}}, byte_i[2:0]};
      end else begin
        upd.err = 1'b1;
      end
    end

    verdict_o = !upd.err && (upd.pending == 2'd0);
    nxt_o     = last_i ? StateClear : upd;
  end

endmodule

`default_nettype wire

[design/utf8_stream_validator_top.sv]
// Strict UTF-8 stream validator: one byte per cycle, verdict on the last byte.
// The last byte passes from the input register through the decode step; its verdict is registered on the master side.
// Throughput: one byte per cycle; a last byte waits in the input register while a verdict is held.
// Reset: async active low; clears decoder state and both valid flags.
// Depends on utf8v_pkg and utf8v_step.
`default_nettype none

module utf8_stream_validator_top
  import utf8v_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] buffer_valid, [7:1] zero
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q, out_vld_d;
  logic       out_bit_q;
  state_t     st_q, st_d;
  state_t     st_nxt;
  logic       verdict;
  logic       advance;
  logic       take_in;

  utf8v_step u_step (
    .cur_i     (st_q),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .nxt_o     (st_nxt),
    .verdict_o (verdict)
  );

  assign advance         = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d  = take_in ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    st_d      = advance ? st_nxt : st_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    if (advance && in_last_q) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= StateClear;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      st_q      <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && in_last_q) begin
      out_bit_q <= verdict;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, out_bit_q};

endmodule

`default_nettype wire
